[hw/rtl/trs_pkg.sv]
// Shared types and fixed-point constants for the TRS matrix composer.
`default_nettype none

package trs_pkg;

  localparam int unsigned QUAT_W = 16;  // Q1.15 quaternion component
  localparam int unsigned VEC_W  = 32;  // Q16.16 translation, scale, result
  localparam int unsigned PROD_W = 2 * QUAT_W;       // quaternion pair product, Q2.30
  localparam int unsigned ROT_W  = PROD_W + 2;       // rotation element, Q4.30
  localparam int unsigned MUL_W  = ROT_W + VEC_W - 1; // element times scale, exact
  localparam int unsigned FRAC_SHIFT = 30;           // Q.46 down to Q16.16
  localparam int unsigned ROUND_W = MUL_W - FRAC_SHIFT;

  localparam logic signed [ROT_W-1:0] ONE_Q30 = ROT_W'(64'sd1 << FRAC_SHIFT);
  localparam logic signed [MUL_W-1:0] HALF_LSB = MUL_W'(64'sd1 << (FRAC_SHIFT - 1));

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [MUL_W-1:0]  mul_t;

  typedef struct packed {
    vec_t  trans_x;
    vec_t  trans_y;
    vec_t  trans_z;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;
    vec_t  scale_x;
    vec_t  scale_y;
    vec_t  scale_z;
  } in_beat_t;

  typedef struct packed {
    vec_t col0_row0;
    vec_t col0_row1;
    vec_t col0_row2;
    vec_t col1_row0;
    vec_t col1_row1;
    vec_t col1_row2;
    vec_t col2_row0;
    vec_t col2_row1;
    vec_t col2_row2;
    vec_t col3_row0;
    vec_t col3_row1;
    vec_t col3_row2;
  } out_beat_t;

endpackage

`default_nettype wire

[hw/rtl/trs_stream_if.sv]
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface trs_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/trs_matrix_from_quaternion.sv]
// An accepted input beat reaches out_beat as its result beat through the
// four pipeline stages (pair products, rotation elements, scale multiply,
// round and saturate), each with its own valid bit. Throughput is one beat
// per cycle while the sink is ready; backpressure ripples stage by stage,
// so bubbles are squeezed out on a stall. Reset (rst_n low, synchronous)
// clears the stage valid bits only; no other state exists between beats.
`default_nettype none

module trs_matrix_from_quaternion (
  input  wire logic   clk,
  input  wire logic   rst_n,
  trs_stream_if.sink   in_beat,
  trs_stream_if.source out_beat
);
  import trs_pkg::*;

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its contents move on.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_beat.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_beat.ready = adv1;

  in_beat_t in_d;
  assign in_d = in_beat.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_beat.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: the nine quaternion pair products, exact in Q2.30.
  // ---------------------------------------------------------------------
  prod_t xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  vec_t  scale1_r [3];
  vec_t  trans1_r [3];

  always_ff @(posedge clk) begin
    if (adv1) begin
      xx_r <= in_d.quat_x * in_d.quat_x;
      yy_r <= in_d.quat_y * in_d.quat_y;
      zz_r <= in_d.quat_z * in_d.quat_z;
      xy_r <= in_d.quat_x * in_d.quat_y;
      xz_r <= in_d.quat_x * in_d.quat_z;
      yz_r <= in_d.quat_y * in_d.quat_z;
      wx_r <= in_d.quat_w * in_d.quat_x;
      wy_r <= in_d.quat_w * in_d.quat_y;
      wz_r <= in_d.quat_w * in_d.quat_z;
      scale1_r[0] <= in_d.scale_x;
      scale1_r[1] <= in_d.scale_y;
      scale1_r[2] <= in_d.scale_z;
      trans1_r[0] <= in_d.trans_x;
      trans1_r[1] <= in_d.trans_y;
      trans1_r[2] <= in_d.trans_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: rotation elements from the doubled products. Index is
  // column * 3 + row, matching the result order.
  // ---------------------------------------------------------------------
  function automatic rot_t dbl(input prod_t p);
    return {p[PROD_W-1], p, 1'b0};
  endfunction

  rot_t rot_nxt [9];
  rot_t rot_r   [9];
  vec_t scale2_r [3];
  vec_t trans2_r [3];

  always_comb begin
    rot_nxt[0] = ONE_Q30 - dbl(yy_r) - dbl(zz_r);
    rot_nxt[1] = dbl(xy_r) + dbl(wz_r);
    rot_nxt[2] = dbl(xz_r) - dbl(wy_r);
    rot_nxt[3] = dbl(xy_r) - dbl(wz_r);
    rot_nxt[4] = ONE_Q30 - dbl(xx_r) - dbl(zz_r);
    rot_nxt[5] = dbl(yz_r) + dbl(wx_r);
    rot_nxt[6] = dbl(xz_r) + dbl(wy_r);
    rot_nxt[7] = dbl(yz_r) - dbl(wx_r);
    rot_nxt[8] = ONE_Q30 - dbl(xx_r) - dbl(yy_r);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      rot_r    <= rot_nxt;
      scale2_r <= scale1_r;
      trans2_r <= trans1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: each element times the scale of its column, exact.
  // ---------------------------------------------------------------------
  mul_t mul_nxt [9];
  mul_t mul_r   [9];
  vec_t trans3_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        mul_nxt[c*3 + r] = MUL_W'(rot_r[c*3 + r] * scale2_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      mul_r    <= mul_nxt;
      trans3_r <= trans2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: round to nearest with ties away from zero, then saturate.
  // For a negative product, adding half minus one before the arithmetic
  // shift gives the same result as rounding the magnitude.
  // ---------------------------------------------------------------------
  localparam logic signed [ROUND_W-1:0] SAT_MAX = ROUND_W'(64'sd2147483647);
  localparam logic signed [ROUND_W-1:0] SAT_MIN = ROUND_W'(-64'sd2147483648);

  function automatic vec_t round_sat(input mul_t p);
    mul_t                      biased;
    logic signed [ROUND_W-1:0] q;
    vec_t                      res;
    biased = p + (p[MUL_W-1] ? (HALF_LSB - MUL_W'(1)) : HALF_LSB);
    q      = ROUND_W'(biased >>> FRAC_SHIFT);
    if (q > SAT_MAX)      res = vec_t'(SAT_MAX);
    else if (q < SAT_MIN) res = vec_t'(SAT_MIN);
    else                  res = q[VEC_W-1:0];
    return res;
  endfunction

  out_beat_t out_nxt;
  out_beat_t out_r;

  always_comb begin
    out_nxt.col0_row0 = round_sat(mul_r[0]);
    out_nxt.col0_row1 = round_sat(mul_r[1]);
    out_nxt.col0_row2 = round_sat(mul_r[2]);
    out_nxt.col1_row0 = round_sat(mul_r[3]);
    out_nxt.col1_row1 = round_sat(mul_r[4]);
    out_nxt.col1_row2 = round_sat(mul_r[5]);
    out_nxt.col2_row0 = round_sat(mul_r[6]);
    out_nxt.col2_row1 = round_sat(mul_r[7]);
    out_nxt.col2_row2 = round_sat(mul_r[8]);
    // Translation column passes straight through.
    out_nxt.col3_row0 = trans3_r[0];
    out_nxt.col3_row1 = trans3_r[1];
    out_nxt.col3_row2 = trans3_r[2];
  end

  // Hold the result beat while the sink stalls.
  always_ff @(posedge clk) begin
    if (adv4) begin
      out_r <= out_nxt;
    end
  end

  assign out_beat.valid = v4_r;
  assign out_beat.data  = out_r;

endmodule

`default_nettype wire
